### hdl/cst_pkg.sv
// Shared types, character codes and helper functions of the character stream tokenizer.
`timescale 1ns / 1ps

package cst_pkg;

    typedef enum logic [3:0] {
        K_EOF    = 4'd0,
        K_IDENT  = 4'd1,
        K_EXTERN = 4'd2,
        K_INT    = 4'd3,
        K_REAL   = 4'd4,
        K_ASSIGN = 4'd5,
        K_ARROW  = 4'd6,
        K_NOTEQ  = 4'd7,
        K_GE     = 4'd8,
        K_LE     = 4'd9,
        K_BREAK  = 4'd10,
        K_CHAR   = 4'd11
    } t_kind;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    localparam logic [2:0]  KW_LEN  = 3'd6;
    localparam logic [62:0] VAL_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [62:0] val;
        logic [15:0] len;
        logic        last;
    } t_token;

    // Up to two tokens caused by one request
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_lex_out;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    function automatic logic is_skip(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
               (c == CH_CR);
    endfunction

    // Letters of the keyword "extern"
    function automatic logic [7:0] kw_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h65;
            3'd1:    c = 8'h78;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hdl/cst_ifs.sv
// Valid/ready channel interfaces for the character and token streams.
`timescale 1ns / 1ps

interface cst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_end;

    modport source (output valid, output char_code, output is_end, input ready);
    modport sink (input valid, input char_code, input is_end, output ready);
endinterface

interface cst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  token_char;
    logic [62:0] int_value;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_char, output int_value,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_char, input int_value,
                  input token_length, input last_of_run, output ready);
endinterface

### hdl/cst_lexer.sv
// Scanner state registers and the single-step transition that yields up to two tokens.
`timescale 1ns / 1ps

module cst_lexer
    import cst_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_end,
    output t_lex_out   o_res
);

    localparam int LB = LENGTH_BITS;
    localparam int LW = (LB > 16) ? LB : 16;
    localparam logic [LB-1:0] LEN_MAX = '1;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_IDENT   = 8'b0000_0010,
        ST_NUM     = 8'b0000_0100,
        ST_GT      = 8'b0000_1000,
        ST_LT      = 8'b0001_0000,
        ST_COLON   = 8'b0010_0000,
        ST_EQ      = 8'b0100_0000,
        ST_COMMENT = 8'b1000_0000
    } t_mode;

    t_mode          r_mode,     n_mode;
    logic           r_prev,     n_prev;
    logic [62:0]    r_val,      n_val;
    logic           r_dot,      n_dot;
    logic           r_oct,      n_oct;
    logic           r_stop,     n_stop;
    logic [LB-1:0]  r_len,      n_len;
    logic [2:0]     r_kw_pos,   n_kw_pos;
    logic           r_kw_miss,  n_kw_miss;

    logic [LW-1:0]  len_wide;
    logic [15:0]    len_out;
    t_token         held_tok;
    logic           held_vld;
    t_token         sec_tok;
    logic           sec_vld;
    logic           use_idle;
    logic           flush_emit;
    logic           eff_prev;
    logic [3:0]     digit;
    logic [66:0]    mac;
    logic [62:0]    val_step;
    logic [LB-1:0]  len_step;
    logic           kw_hit;

    // Token held by the current mode
    always_comb begin
        len_wide = LW'(r_len);
        len_out  = (len_wide > LW'(16'hFFFF)) ? 16'hFFFF : len_wide[15:0];
        held_tok = '0;
        held_vld = 1'b0;
        unique case (r_mode)
            ST_IDENT: begin
                held_vld     = 1'b1;
                held_tok.kind = (!r_kw_miss && r_kw_pos == KW_LEN) ? K_EXTERN : K_IDENT;
                held_tok.len  = len_out;
            end
            ST_NUM: begin
                held_vld      = 1'b1;
                held_tok.kind = r_dot ? K_REAL : K_INT;
                held_tok.val  = r_dot ? '0 : r_val;
                held_tok.len  = len_out;
            end
            ST_GT: begin
                held_vld      = 1'b1;
                held_tok.kind = K_CHAR;
                held_tok.ch   = CH_GT;
            end
            ST_LT: begin
                held_vld      = 1'b1;
                held_tok.kind = K_CHAR;
                held_tok.ch   = CH_LT;
            end
            ST_COLON: begin
                held_vld      = 1'b1;
                held_tok.kind = K_CHAR;
                held_tok.ch   = CH_COLON;
            end
            ST_EQ: begin
                held_vld      = 1'b1;
                held_tok.kind = K_CHAR;
                held_tok.ch   = CH_EQ;
            end
            ST_IDLE, ST_COMMENT: begin
                held_vld = 1'b0;
            end
            default: begin
                held_vld = 1'b0;
            end
        endcase
    end

    // Digit accumulate: shift-add by 8 or 10, saturate at the largest signed value
    always_comb begin
        digit    = i_char[3:0];
        mac      = r_oct ? 67'({r_val, 3'b000})
                         : 67'({r_val, 3'b000}) + 67'({r_val, 1'b0});
        mac      = mac + 67'(digit);
        val_step = (mac > 67'(VAL_MAX)) ? VAL_MAX : mac[62:0];
        len_step = (r_len != LEN_MAX) ? r_len + LB'(1) : r_len;
        kw_hit   = (r_kw_pos < KW_LEN) && (i_char == kw_char(r_kw_pos));
        eff_prev = held_vld ? 1'b0 : r_prev;
    end

    always_comb begin
        n_mode    = r_mode;
        n_prev    = r_prev;
        n_val     = r_val;
        n_dot     = r_dot;
        n_oct     = r_oct;
        n_stop    = r_stop;
        n_len     = r_len;
        n_kw_pos  = r_kw_pos;
        n_kw_miss = r_kw_miss;
        sec_tok   = '0;
        sec_vld   = 1'b0;
        use_idle  = 1'b0;
        flush_emit = 1'b0;
        o_res     = '0;

        if (i_end) begin
            flush_emit   = held_vld;
            sec_vld      = 1'b1;
            sec_tok.kind = K_EOF;
            n_mode       = ST_IDLE;
        end else begin
            unique case (r_mode)
                ST_IDENT: begin
                    if (is_alpha(i_char) || is_digit(i_char)) begin
                        n_len = len_step;
                        if (!r_kw_miss) begin
                            if (kw_hit) n_kw_pos = r_kw_pos + 3'd1;
                            else n_kw_miss = 1'b1;
                        end
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                ST_NUM: begin
                    if (is_digit(i_char)) begin
                        n_len = len_step;
                        if (!r_stop) begin
                            if (r_oct && digit >= 4'd8) n_stop = 1'b1;
                            else n_val = val_step;
                        end
                    end else if (i_char == CH_DOT && !r_dot) begin
                        n_len = len_step;
                        n_dot = 1'b1;
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                ST_GT: begin
                    if (i_char == CH_EQ) begin
                        n_mode       = ST_IDLE;
                        sec_vld      = 1'b1;
                        sec_tok.kind = K_GE;
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                ST_LT: begin
                    if (i_char == CH_EQ) begin
                        n_mode       = ST_IDLE;
                        sec_vld      = 1'b1;
                        sec_tok.kind = K_LE;
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                ST_COLON: begin
                    if (i_char == CH_EQ) begin
                        n_mode       = ST_IDLE;
                        sec_vld      = 1'b1;
                        sec_tok.kind = K_ASSIGN;
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                ST_EQ: begin
                    if (i_char == CH_GT) begin
                        n_mode       = ST_IDLE;
                        sec_vld      = 1'b1;
                        sec_tok.kind = K_ARROW;
                    end else if (i_char == CH_SLASH) begin
                        n_mode       = ST_IDLE;
                        sec_vld      = 1'b1;
                        sec_tok.kind = K_NOTEQ;
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                ST_COMMENT: begin
                    if (i_char == CH_DOLLAR || i_char == CH_NL || i_char == CH_CR) begin
                        n_mode = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    use_idle = 1'b1;
                end
                default: begin
                    use_idle = 1'b1;
                end
            endcase
        end

        // Flush whatever is held, then lex the character afresh
        if (use_idle) begin
            flush_emit = held_vld;
            n_mode     = ST_IDLE;
            if (is_skip(i_char)) begin
                n_mode = ST_IDLE;
            end else if (is_alpha(i_char)) begin
                n_mode    = ST_IDENT;
                n_val     = '0;
                n_dot     = 1'b0;
                n_oct     = 1'b0;
                n_stop    = 1'b0;
                n_len     = LB'(1);
                n_kw_pos  = (i_char == kw_char(3'd0)) ? 3'd1 : 3'd0;
                n_kw_miss = (i_char != kw_char(3'd0));
            end else if (is_digit(i_char) || i_char == CH_DOT) begin
                n_mode    = ST_NUM;
                n_dot     = (i_char == CH_DOT);
                n_val     = (i_char == CH_DOT) ? '0 : 63'(digit);
                n_oct     = (i_char == CH_ZERO);
                n_stop    = 1'b0;
                n_len     = LB'(1);
                n_kw_pos  = 3'd0;
                n_kw_miss = 1'b0;
            end else if (i_char == CH_GT) begin
                n_mode = ST_GT;
            end else if (i_char == CH_LT) begin
                n_mode = ST_LT;
            end else if (i_char == CH_COLON) begin
                n_mode = ST_COLON;
            end else if (i_char == CH_EQ) begin
                n_mode = ST_EQ;
            end else if (i_char == CH_DOLLAR) begin
                n_mode = ST_COMMENT;
            end else if (i_char == CH_SEMI || i_char == CH_NL) begin
                // Collapse repeated line breaks
                if (!eff_prev) begin
                    sec_vld      = 1'b1;
                    sec_tok.kind = K_BREAK;
                end
            end else begin
                sec_vld      = 1'b1;
                sec_tok.kind = K_CHAR;
                sec_tok.ch   = i_char;
            end
        end

        if (sec_vld) n_prev = (sec_tok.kind == K_BREAK);
        else if (flush_emit) n_prev = 1'b0;

        if (flush_emit && sec_vld) begin
            o_res.cnt       = 2'd2;
            o_res.tok0      = held_tok;
            o_res.tok1      = sec_tok;
            o_res.tok1.last = 1'b1;
        end else if (flush_emit) begin
            o_res.cnt       = 2'd1;
            o_res.tok0      = held_tok;
            o_res.tok0.last = 1'b1;
        end else if (sec_vld) begin
            o_res.cnt       = 2'd1;
            o_res.tok0      = sec_tok;
            o_res.tok0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ST_IDLE;
            r_prev    <= 1'b0;
            r_val     <= '0;
            r_dot     <= 1'b0;
            r_oct     <= 1'b0;
            r_stop    <= 1'b0;
            r_len     <= '0;
            r_kw_pos  <= 3'd0;
            r_kw_miss <= 1'b0;
        end else if (i_take) begin
            r_mode    <= n_mode;
            r_prev    <= n_prev;
            r_val     <= n_val;
            r_dot     <= n_dot;
            r_oct     <= n_oct;
            r_stop    <= n_stop;
            r_len     <= n_len;
            r_kw_pos  <= n_kw_pos;
            r_kw_miss <= n_kw_miss;
        end
    end

`ifndef SYNTHESIS
    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_end) |=> (r_mode == ST_IDLE))
        else $error("lexer not idle after end mark");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.cnt == 2'd2) |-> (o_res.tok1.last && !o_res.tok0.last))
        else $error("last flag misplaced on a token pair");

    a_comment_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_end && r_mode == ST_COMMENT) |-> (o_res.cnt == 2'd0))
        else $error("token emitted inside a comment");
`endif

endmodule

### hdl/cst_res_queue.sv
// Four-entry result queue: takes up to two tokens per request, delivers one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module cst_res_queue
    import cst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_lex_out i_res,
    output logic     o_space,
    output logic     o_valid,
    input  logic     i_ready,
    output t_token   o_tok
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_token        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;
    logic          pop;
    logic [PW:0]   push_n;

    assign pop     = o_valid && i_ready;
    assign push_n  = i_push ? (PW+1)'(i_res.cnt) : '0;
    assign o_space = (r_count <= (PW+1)'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= r_count + push_n - (PW+1)'(pop);
            if (pop) r_rd <= r_rd + PW'(1);
            if (i_push) r_wr <= r_wr + PW'(i_res.cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_res.cnt != 2'd0) r_mem[r_wr] <= i_res.tok0;
        if (i_push && i_res.cnt == 2'd2) r_mem[r_wr + PW'(1)] <= i_res.tok1;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(DEPTH))
        else $error("result queue overflow");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + (PW+1)'($past(i_res.cnt))))
        else $error("queue count does not follow a push");

    a_rd_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_rd == $past(r_rd) + PW'(1)))
        else $error("read pointer did not advance on pop");
`endif

endmodule

### hdl/char_stream_tokenizer_core.sv
// Character stream tokenizer: lexes one character per request into identifier, number and
// operator tokens.
//
// i_in carries one ASCII byte per request (char_code), or an end-of-input mark (is_end).
// o_out carries tokens: kind, single character, integer value, length and a flag on the
// last token caused by a request.
// Each request updates the scanner state in the cycle it is accepted; the tokens it
// causes go through the result queue to o_out, one per cycle while the receiver is ready,
// in order. A request causes zero, one or two tokens. The block takes one request per
// cycle while requests cause at most one token and the receiver keeps up; the two-token
// case is limited by the one-token-per-cycle output side.
// A four-entry result queue parts the two sides: i_in.ready is high while it has room for
// two tokens, so a stalled receiver holds back requests only once the queue is that full.
// A token that needs one character of lookahead is held in the scanner until the next
// request decides it; an end mark flushes it and adds an eof token.
// Synchronous active-low reset empties the queue and returns the scanner to idle; the
// block takes requests as soon as reset is released.

`timescale 1ns / 1ps

module char_stream_tokenizer_core
    import cst_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cst_in_if.sink     i_in,
    cst_out_if.source  o_out
);

    t_lex_out lex_res;
    t_token   q_tok;
    logic     q_space;
    logic     q_valid;
    logic     take;

    assign i_in.ready = q_space;
    assign take       = i_in.valid && q_space;

    cst_lexer #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (i_in.char_code),
        .i_end   (i_in.is_end),
        .o_res   (lex_res)
    );

    cst_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_res   (lex_res),
        .o_space (q_space),
        .o_valid (q_valid),
        .i_ready (o_out.ready),
        .o_tok   (q_tok)
    );

    assign o_out.valid        = q_valid;
    assign o_out.token_kind   = q_tok.kind;
    assign o_out.token_char   = q_tok.ch;
    assign o_out.int_value    = q_tok.val;
    assign o_out.token_length = q_tok.len;
    assign o_out.last_of_run  = q_tok.last;

endmodule

### sim/char_stream_tokenizer_core_tb.sv
// Self-checking testbench of the character stream tokenizer: directed and random requests.
`timescale 1ns / 1ps

module char_stream_tokenizer_core_tb;
    import cst_pkg::*;

    localparam int LEN_BITS     = 16;
    localparam int RANDOM_ITEMS = 880;
    localparam int LONG_WORD    = 40;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        SM_IDLE, SM_IDENT, SM_NUM, SM_GT, SM_LT, SM_COLON, SM_EQ, SM_COMMENT
    } t_scan;

    // Tracks the lexer state and holds the tokens still to come from the block
    class token_tracker;
        t_scan       mode;
        bit          after_break;
        logic [62:0] acc;
        bit          dotted;
        bit          octal;
        bit          stopped;
        int unsigned len;
        int unsigned kw_pos;
        bit          kw_miss;
        t_token      pending_tokens[$];
        t_token      step_toks[$];
        int          errors;
        int          checked;
        int          requests;
        bit [11:0]   kinds_seen;

        function new();
            mode        = SM_IDLE;
            after_break = 1'b0;
            errors      = 0;
            checked     = 0;
            requests    = 0;
            kinds_seen  = '0;
            clear_word();
        endfunction

        function void clear_word();
            acc     = '0;
            dotted  = 1'b0;
            octal   = 1'b0;
            stopped = 1'b0;
            len     = 0;
            kw_pos  = 0;
            kw_miss = 1'b0;
        endfunction

        function bit is_letter(logic [7:0] c);
            logic [7:0] lc;
            lc = c | 8'h20;
            return (c < 8'h80) && (lc >= "a") && (lc <= "z");
        endfunction

        function bit is_numeral(logic [7:0] c);
            return (c >= CH_ZERO) && (c <= CH_NINE);
        endfunction

        function void emit(t_kind k, logic [7:0] ch, logic [62:0] v, int unsigned n);
            t_token t;
            if (step_toks.size() >= 2) return;
            t.kind = k;
            t.ch   = ch;
            t.val  = v;
            t.len  = (n > 65535) ? 16'hFFFF : n[15:0];
            t.last = 1'b0;
            step_toks.push_back(t);
            after_break = (k == K_BREAK);
        endfunction

        function void bump_len();
            if (len < (2 ** LEN_BITS) - 1) len++;
        endfunction

        function void match_kw(logic [7:0] c);
            string kw;
            kw = "extern";
            if (kw_miss) return;
            if (kw_pos < KW_LEN && c == kw[kw_pos]) kw_pos++;
            else kw_miss = 1'b1;
        endfunction

        // Octal stops at the first 8 or 9; the value saturates
        function void add_digit(int unsigned d);
            logic [63:0] base;
            if (stopped) return;
            if (octal && d >= 8) begin
                stopped = 1'b1;
                return;
            end
            base = octal ? 64'd8 : 64'd10;
            if ({1'b0, acc} > ({1'b0, VAL_MAX} - 64'(d)) / base) acc = VAL_MAX;
            else acc = 63'({1'b0, acc} * base + 64'(d));
        endfunction

        function void start_char(logic [7:0] c);
            mode = SM_IDLE;
            if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) return;
            if (is_letter(c)) begin
                clear_word();
                mode = SM_IDENT;
                bump_len();
                match_kw(c);
                return;
            end
            if (is_numeral(c) || c == CH_DOT) begin
                clear_word();
                mode = SM_NUM;
                bump_len();
                if (c == CH_DOT) begin
                    dotted = 1'b1;
                end else begin
                    octal = (c == CH_ZERO);
                    add_digit(c - CH_ZERO);
                end
                return;
            end
            case (c)
                CH_GT:     mode = SM_GT;
                CH_LT:     mode = SM_LT;
                CH_COLON:  mode = SM_COLON;
                CH_EQ:     mode = SM_EQ;
                CH_DOLLAR: mode = SM_COMMENT;
                CH_SEMI, CH_NL: begin
                    if (!after_break) emit(K_BREAK, 8'h00, '0, 0);
                end
                default:   emit(K_CHAR, c, '0, 0);
            endcase
        endfunction

        // Release the token held for lookahead
        function void flush_held();
            case (mode)
                SM_IDENT: begin
                    if (!kw_miss && kw_pos == KW_LEN) emit(K_EXTERN, 8'h00, '0, len);
                    else emit(K_IDENT, 8'h00, '0, len);
                end
                SM_NUM: begin
                    if (dotted) emit(K_REAL, 8'h00, '0, len);
                    else emit(K_INT, 8'h00, acc, len);
                end
                SM_GT:    emit(K_CHAR, CH_GT, '0, 0);
                SM_LT:    emit(K_CHAR, CH_LT, '0, 0);
                SM_COLON: emit(K_CHAR, CH_COLON, '0, 0);
                SM_EQ:    emit(K_CHAR, CH_EQ, '0, 0);
                default: ;
            endcase
            mode = SM_IDLE;
        endfunction

        function void note_char(logic [7:0] c, logic is_end);
            t_token t;
            step_toks.delete();
            requests++;
            if (is_end) begin
                flush_held();
                emit(K_EOF, 8'h00, '0, 0);
            end else begin
                case (mode)
                    SM_IDENT: begin
                        if (is_letter(c) || is_numeral(c)) begin
                            bump_len();
                            match_kw(c);
                        end else begin
                            flush_held();
                            start_char(c);
                        end
                    end
                    SM_NUM: begin
                        if (is_numeral(c)) begin
                            bump_len();
                            add_digit(c - CH_ZERO);
                        end else if (c == CH_DOT && !dotted) begin
                            bump_len();
                            dotted = 1'b1;
                        end else begin
                            flush_held();
                            start_char(c);
                        end
                    end
                    SM_GT, SM_LT, SM_COLON: begin
                        if (c == CH_EQ) begin
                            if (mode == SM_GT) emit(K_GE, 8'h00, '0, 0);
                            else if (mode == SM_LT) emit(K_LE, 8'h00, '0, 0);
                            else emit(K_ASSIGN, 8'h00, '0, 0);
                            mode = SM_IDLE;
                        end else begin
                            flush_held();
                            start_char(c);
                        end
                    end
                    SM_EQ: begin
                        if (c == CH_GT) begin
                            mode = SM_IDLE;
                            emit(K_ARROW, 8'h00, '0, 0);
                        end else if (c == CH_SLASH) begin
                            mode = SM_IDLE;
                            emit(K_NOTEQ, 8'h00, '0, 0);
                        end else begin
                            flush_held();
                            start_char(c);
                        end
                    end
                    SM_COMMENT: begin
                        if (c == CH_DOLLAR || c == CH_NL || c == CH_CR) mode = SM_IDLE;
                    end
                    default: start_char(c);
                endcase
            end
            foreach (step_toks[i]) begin
                t = step_toks[i];
                t.last = (i == step_toks.size() - 1);
                pending_tokens.push_back(t);
            end
        endfunction

        function void check_token(logic [3:0] kind, logic [7:0] ch, logic [62:0] val,
                                  logic [15:0] len_act, logic last);
            t_token t;
            if (pending_tokens.size() == 0) begin
                $error("token with no request to explain it: kind %0d", kind);
                errors++;
                return;
            end
            t = pending_tokens.pop_front();
            checked++;
            kinds_seen[kind] = 1'b1;
            if (kind !== t.kind) begin
                $error("token_kind: expected %0d, got %0d", t.kind, kind);
                errors++;
            end
            if (ch !== t.ch) begin
                $error("token_char: expected %0h, got %0h", t.ch, ch);
                errors++;
            end
            if (val !== t.val) begin
                $error("int_value: expected %0d, got %0d", t.val, val);
                errors++;
            end
            if (len_act !== t.len) begin
                $error("token_length: expected %0d, got %0d", t.len, len_act);
                errors++;
            end
            if (last !== t.last) begin
                $error("last_of_run: expected %0b, got %0b", t.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cst_in_if  in_if ();
    cst_out_if out_if ();

    char_stream_tokenizer_core #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    token_tracker tracker = new();

    bit calm      = 1'b0;
    bit hold_due  = 1'b0;
    bit hold_done = 1'b0;
    bit holding   = 1'b0;
    int sent_count = 0;

    string op_texts[12] = '{">=", "<=", ":=", "=>", "=/", ">", "<", ":", "=", "==", "=<", ">>"};
    string kw_texts[6]  = '{"extern", "exter", "externs", "EXTERN", "extern1", "xtern"};

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) tracker.note_char(in_if.char_code, in_if.is_end);
            if (out_if.valid && out_if.ready) begin
                tracker.check_token(out_if.token_kind, out_if.token_char, out_if.int_value,
                                    out_if.token_length, out_if.last_of_run);
            end
        end
    end

    // Receiver: random stalls, one long hold-off so the block fills and backs up
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            if (hold_due && !hold_done) begin
                holding = 1'b1;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
                holding   = 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                out_if.ready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 3) == 0) return CH_ZERO + 8'($urandom_range(0, 9));
        return rand_letter();
    endfunction

    task automatic send_request(input logic [7:0] c, input bit e);
        int gap;
        gap = 0;
        if (!calm && !holding && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.char_code <= c;
        in_if.is_end    <= e;
        do @(posedge i_clk); while (!in_if.ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_number();
        int n;
        bit zero_lead;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
        zero_lead = ($urandom_range(0, 2) == 0);
        if (zero_lead) send_request(CH_ZERO, 1'b0);
        repeat (n) begin
            if ($urandom_range(0, 11) == 0) send_request(CH_DOT, 1'b0);
            else if (zero_lead && $urandom_range(0, 3) != 0)
                send_request(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
            else send_request(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
    endtask

    task automatic send_comment();
        logic [7:0] c;
        send_request(CH_DOLLAR, 1'b0);
        repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_DOLLAR || c == CH_NL || c == CH_CR);
            send_request(c, 1'b0);
        end
        case ($urandom_range(0, 3))
            0:       send_request(CH_DOLLAR, 1'b0);
            1:       send_request(CH_NL, 1'b0);
            2:       send_request(CH_CR, 1'b0);
            default: send_end();
        endcase
    endtask

    task automatic send_random_fragment();
        logic [7:0] blanks[5];
        string      punct;
        blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        punct  = "+-*(),[] ";
        case ($urandom_range(0, 11))
            0, 1: begin
                if ($urandom_range(0, 3) == 0) begin
                    send_text(kw_texts[$urandom_range(0, 5)]);
                end else begin
                    send_request(rand_letter(), 1'b0);
                    repeat ($urandom_range(0, 7)) send_request(rand_alnum(), 1'b0);
                end
            end
            2, 3: send_number();
            4:    send_text(op_texts[$urandom_range(0, 11)]);
            5: begin
                repeat ($urandom_range(1, 3)) begin
                    send_request($urandom_range(0, 1) ? CH_SEMI : CH_NL, 1'b0);
                    if ($urandom_range(0, 2) == 0) send_request(blanks[$urandom_range(0, 4)], 1'b0);
                    else if ($urandom_range(0, 3) == 0) send_text("$x$");
                end
            end
            6:    repeat ($urandom_range(1, 3)) send_request(blanks[$urandom_range(0, 4)], 1'b0);
            7:    send_comment();
            8:    send_request(8'($urandom_range(0, 255)), 1'b0);
            9: begin
                if ($urandom_range(0, 2) == 0) send_end();
                else send_request(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
            end
            default: send_request(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
        endcase
    endtask

    initial begin
        int rand_start;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.char_code <= 8'h00;
        in_if.is_end    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every pair, keyword, octal stop, collapsed breaks, raw bytes, lone dot, end marks
        send_text("extern<=:==>=/>=0789;$c$;");
        send_request(8'hFF, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(CH_DOT, 1'b0);
        send_end();
        send_request(CH_DOLLAR, 1'b0);
        send_end();

        // A long identifier
        send_request(rand_letter(), 1'b0);
        repeat (LONG_WORD) send_request(rand_alnum(), 1'b0);
        send_request(CH_SPACE, 1'b0);

        rand_start = sent_count;
        while (sent_count - rand_start < RANDOM_ITEMS) begin
            if (sent_count - rand_start >= 300) hold_due = 1'b1;
            if (sent_count - rand_start >= RANDOM_ITEMS * 17 / 20) calm = 1'b1;
            send_random_fragment();
        end
        send_end();
        in_if.valid <= 1'b0;

        while (tracker.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d tokens, %0d of 12 token kinds,",
                 tracker.requests, tracker.checked, $countones(tracker.kinds_seen));
        $display("a %0d-character identifier, saturating numbers and a %0d-cycle output stall.",
                 LONG_WORD + 1, LONG_HOLD);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
